### design/nfsa_pkg.sv
// Shared types, constants and helper functions for the next-fit slot allocator.
// No dependencies; used by every other file of the block except nfsa_ram.
`timescale 1ns / 1ps

package nfsa_pkg;

  // Slot table geometry
  localparam int SLOT_W  = 10;
  localparam int SLOTS   = 1 << SLOT_W;
  localparam int FREE_W  = SLOT_W + 1;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = SLOTS / WORD_W;
  localparam int WADDR_W = SLOT_W - BIT_W;

  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS - 1);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_GRANTED     = 2'd0,
    ST_FULL        = 2'd1,
    ST_RELEASED    = 2'd2,
    ST_BAD_RELEASE = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the request
    logic early;     // resolve without a bitmap read (table full)
    logic check;     // examine the word just read
    logic out_load;  // move the result into the output register
  } nfsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic early_done;  // request resolves without reading the bitmap
    logic done;        // current word check ends the request
  } nfsa_stat_t;

  // Lowest set bit of a word
  function automatic logic [BIT_W-1:0] find_first(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

  // Highest set bit of a word
  function automatic logic [BIT_W-1:0] find_last(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

### design/nfsa_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on nfsa_pkg for field widths and codes.
`timescale 1ns / 1ps

interface nfsa_req_if;
  logic                        valid;
  logic                        ready;
  nfsa_pkg::op_e               operation;
  logic [nfsa_pkg::SLOT_W-1:0] release_slot;

  modport source (output valid, output operation, output release_slot, input ready);
  modport sink   (input valid, input operation, input release_slot, output ready);
endinterface

interface nfsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nfsa_pkg::SLOT_W-1:0] slot;
  nfsa_pkg::status_e           status;
  logic [nfsa_pkg::FREE_W-1:0] free_slots;

  modport source (output valid, output slot, output status, output free_slots, input ready);
  modport sink   (input valid, input slot, input status, input free_slots, output ready);
endinterface

### design/next_fit_slot_allocator.sv
// Next-fit slot allocator over a 1024-entry table: top level tying the
// sequencer to the datapath. Depends on nfsa_pkg, nfsa_if, nfsa_ctrl, nfsa_dp.
//
// One request is handled at a time. The occupancy bitmap sits in a 32 x 32-bit
// RAM, and each word visited takes a lookup state (address), then a check
// state (check and write back). A release, or a grant found in the hint word,
// visits a single word; a full table skips the bitmap check, and an allocate
// that must scan visits up to 33 words. Per-word valid bits make the whole
// table free right after reset, with no clearing pass. The result sits in an
// output register, so a new request is accepted while the previous
// transaction still waits to be taken.
`timescale 1ns / 1ps

module next_fit_slot_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  nfsa_req_if.sink   req_i,
  nfsa_rsp_if.source rsp_o
);
  import nfsa_pkg::*;

  nfsa_cmd_t  cmd;
  nfsa_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  nfsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(rsp_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nfsa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (req_i.operation),
    .in_slot_i   (req_i.release_slot),
    .out_slot_o  (rsp_o.slot),
    .out_status_o(rsp_o.status),
    .out_free_o  (rsp_o.free_slots)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

### design/nfsa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nfsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

### design/nfsa_ctrl.sv
// Sequencer for the slot allocator: accept, bitmap lookup loop, result hand-off.
// Depends on nfsa_pkg for the command and status structs.
`timescale 1ns / 1ps

module nfsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  nfsa_pkg::nfsa_stat_t stat_i,
  output nfsa_pkg::nfsa_cmd_t  cmd_o
);
  import nfsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Commands decoded from the current state
  always_comb begin
    in_ready_o     = (state_q == S_IDLE);
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.early    = (state_q == S_LOOKUP) && stat_i.early_done;
    cmd_o.check    = (state_q == S_CHECK);
    cmd_o.out_load = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_d = stat_i.early_done ? S_RESULT : S_CHECK;
      end
      S_CHECK: begin
        state_d = stat_i.done ? S_RESULT : S_LOOKUP;
      end
      S_RESULT: begin
        if (cmd_o.out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared once the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/nfsa_dp.sv
// Datapath: occupancy bitmap RAM with per-word valid bits, hint, free count,
// word scan pointer and result/output registers. Depends on nfsa_pkg, nfsa_ram.
`timescale 1ns / 1ps

module nfsa_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nfsa_pkg::nfsa_cmd_t         cmd_i,
  output nfsa_pkg::nfsa_stat_t        stat_o,
  input  nfsa_pkg::op_e               in_op_i,
  input  logic [nfsa_pkg::SLOT_W-1:0] in_slot_i,
  output logic [nfsa_pkg::SLOT_W-1:0] out_slot_o,
  output nfsa_pkg::status_e           out_status_o,
  output logic [nfsa_pkg::FREE_W-1:0] out_free_o
);
  import nfsa_pkg::*;

  // Control state
  logic [SLOT_W-1:0]  hint_q;
  logic [FREE_W-1:0]  free_q;
  logic [WADDR_W-1:0] ptr_q;
  logic               bwd_q;
  logic [WORDS-1:0]   valid_q;

  // Payload
  op_e                op_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [SLOT_W-1:0]  res_slot_q;
  status_e            res_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  status_e            out_status_q;
  logic [FREE_W-1:0]  out_free_q;

  logic [WADDR_W-1:0] hint_word;
  logic [BIT_W-1:0]   hint_bit;
  logic [BIT_W-1:0]   idx_bit;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_we;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  free_vec;
  logic [WORD_W-1:0]  window;
  logic [WORD_W-1:0]  cand;
  logic [WORD_W-1:0]  bit_sel;
  logic [BIT_W-1:0]   pos;
  logic               at_hint;
  logic               hint_free;
  logic               found;
  logic               rel_ok;
  logic               is_rel;

  // Bitmap storage, one word per address; the address is always the scan pointer
  nfsa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ptr_q),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Word check: never-written words read as all free
  always_comb begin
    hint_word = hint_q[SLOT_W-1:BIT_W];
    hint_bit  = hint_q[BIT_W-1:0];
    idx_bit   = idx_q[BIT_W-1:0];
    is_rel    = (op_q == OP_RELEASE);
    word      = valid_q[ptr_q] ? ram_rdata : '0;
    free_vec  = ~word;
    at_hint   = (ptr_q == hint_word);

    // forward pass looks at and above the hint bit, backward pass below it
    if (!at_hint)   window = '1;
    else if (bwd_q) window = ~({WORD_W{1'b1}} << hint_bit);
    else            window = ({WORD_W{1'b1}} << hint_bit) << 1;
    cand = free_vec & window;

    hint_free = !bwd_q && at_hint && free_vec[hint_bit];
    if (hint_free)  pos = hint_bit;
    else if (bwd_q) pos = find_last(cand);
    else            pos = find_first(cand);
    found  = hint_free || (cand != '0);
    rel_ok = word[idx_bit];

    stat_o.early_done = !is_rel && (free_q == '0);
    stat_o.done       = is_rel || found;

    bit_sel   = WORD_W'(1) << (is_rel ? idx_bit : pos);
    ram_wdata = is_rel ? (word & ~bit_sel) : (word | bit_sel);
    ram_we    = cmd_i.check && (is_rel ? rel_ok : found);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_q  <= '0;
      free_q  <= FREE_W'(SLOTS);
      ptr_q   <= '0;
      bwd_q   <= 1'b0;
      valid_q <= '0;
    end else begin
      if (cmd_i.load) begin
        ptr_q <= (in_op_i == OP_RELEASE) ? in_slot_i[SLOT_W-1:BIT_W] : hint_word;
        bwd_q <= 1'b0;
      end
      if (ram_we) valid_q[ptr_q] <= 1'b1;
      if (cmd_i.check) begin
        if (is_rel) begin
          if (rel_ok) begin
            free_q <= free_q + FREE_W'(1);
            hint_q <= idx_q;
          end
        end else if (found) begin
          free_q <= free_q - FREE_W'(1);
          if (hint_free) hint_q <= (hint_q == LAST_SLOT) ? '0 : hint_q + SLOT_W'(1);
        end else if (!bwd_q && ptr_q == LAST_WORD) begin
          // forward pass hit the end: rescan the hint word below the hint
          bwd_q <= 1'b1;
          ptr_q <= hint_word;
        end else if (!bwd_q) begin
          ptr_q <= ptr_q + WADDR_W'(1);
        end else begin
          ptr_q <= ptr_q - WADDR_W'(1);
        end
      end
    end
  end

  // Request, result and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      idx_q <= in_slot_i;
    end
    if (cmd_i.early) begin
      res_slot_q   <= '0;
      res_status_q <= ST_FULL;
    end else if (cmd_i.check) begin
      if (is_rel) begin
        res_slot_q   <= idx_q;
        res_status_q <= rel_ok ? ST_RELEASED : ST_BAD_RELEASE;
      end else if (found) begin
        res_slot_q   <= {ptr_q, pos};
        res_status_q <= ST_GRANTED;
      end
    end
    if (cmd_i.out_load) begin
      out_slot_q   <= res_slot_q;
      out_status_q <= res_status_q;
      out_free_q   <= free_q;
    end
  end

  assign out_slot_o   = out_slot_q;
  assign out_status_o = out_status_q;
  assign out_free_o   = out_free_q;

  // Checks
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FREE_W'(SLOTS))
    else $error("free count above table size");

  a_grant_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check && !is_rel && found |=> free_q == $past(free_q) - FREE_W'(1))
    else $error("grant did not consume a free slot");

  a_grant_free_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check && !is_rel && found |-> !word[pos])
    else $error("grant picked an occupied slot");

  a_release_hint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check && is_rel && rel_ok |=> hint_q == $past(idx_q))
    else $error("release did not move the hint");

endmodule
